@@ rtl/trc_pkg.sv @@
// trc_pkg: shared constants for the thermostat relay controller
// register indexes, mode codes and field widths
// used by thermostat_relay_controller
package trc_pkg;

  // field widths
  localparam int TempW      = 12;
  localparam int ModeW      = 2;
  localparam int HystW      = 8;
  localparam int DelayW     = 8;
  localparam int AlarmW     = 9;
  localparam int CountW     = 16;
  localparam int CfgIndexW  = 3;
  localparam int CfgDataW   = 12;

  // switch delay is counted in units of 1 << DelayShift ticks
  localparam int DelayShift = 7;

  // hysteresis is scaled down by 1 << HystShift before use
  localparam int HystShift  = 3;

  typedef logic [CfgIndexW-1:0] cfg_index_t;
  typedef logic [ModeW-1:0]     mode_t;

  // configuration register indexes
  localparam cfg_index_t REG_RELAY_MODE   = 3'd0;
  localparam cfg_index_t REG_THRESHOLD    = 3'd1;
  localparam cfg_index_t REG_HYSTERESIS   = 3'd2;
  localparam cfg_index_t REG_SWITCH_DELAY = 3'd3;
  localparam cfg_index_t REG_ALARM_LOW    = 3'd4;
  localparam cfg_index_t REG_ALARM_HIGH   = 3'd5;

  // relay modes
  localparam mode_t MODE_NORMAL   = 2'd0;
  localparam mode_t MODE_INVERTED = 2'd1;
  localparam mode_t MODE_ALARM    = 2'd2;

endpackage

@@ rtl/thermostat_relay_controller.sv @@
// thermostat_relay_controller: hysteresis relay control with delay and alarm window
// single registered step per temperature sample
// depends on trc_pkg
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid, in_ready, temperature           | in
//   output   | out_valid, out_ready, relay_on, active    | out
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// one sample per clock unless the result stalls: flag and delay counter update in the
// accept cycle, and the result register holds the outcome from the next cycle on.
// input is taken whenever the result register is empty or being drained.
// the config port is always ready; writes are registered and take effect from the next cycle.
// synchronous reset clears the flag, the counter and the result valid, and
// loads the register defaults.
module thermostat_relay_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [trc_pkg::TempW-1:0]     temperature,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          relay_on,
  output logic                          active,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [trc_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [trc_pkg::CfgDataW-1:0]  cfg_data
);
  import trc_pkg::*;

  localparam int WideW = TempW + 1;

  // configuration registers
  mode_t                     relay_mode;
  logic signed [TempW-1:0]   threshold;
  logic [HystW-1:0]          hysteresis;
  logic [DelayW-1:0]         switch_delay;
  logic signed [AlarmW-1:0]  alarm_low;
  logic signed [AlarmW-1:0]  alarm_high;

  // controller state
  logic                      active_flag;
  logic                      active_flag_next;
  logic [CountW-1:0]         delay_count;
  logic [CountW-1:0]         delay_count_next;

  // derived values
  logic                      window_mode;
  logic                      invert;
  logic                      in_xfer;
  logic signed [WideW-1:0]   temp_w;
  logic signed [WideW-1:0]   thr_w;
  logic signed [WideW-1:0]   band;
  logic signed [WideW-1:0]   upper;
  logic signed [WideW-1:0]   lower;
  logic signed [WideW-1:0]   win_lo;
  logic signed [WideW-1:0]   win_hi;
  logic [CountW-1:0]         limit;
  logic [CountW-1:0]         count_inc;
  logic                      cond;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      relay_mode   <= MODE_NORMAL;
      threshold    <= 12'sd280;
      hysteresis   <= 8'd16;
      switch_delay <= 8'd0;
      alarm_low    <= -9'sd50;
      alarm_high   <= 9'sd110;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RELAY_MODE:   relay_mode   <= cfg_data[ModeW-1:0];
        REG_THRESHOLD:    threshold    <= cfg_data[TempW-1:0];
        REG_HYSTERESIS:   hysteresis   <= cfg_data[HystW-1:0];
        REG_SWITCH_DELAY: switch_delay <= cfg_data[DelayW-1:0];
        REG_ALARM_LOW:    alarm_low    <= cfg_data[AlarmW-1:0];
        REG_ALARM_HIGH:   alarm_high   <= cfg_data[AlarmW-1:0];
        default: ;
      endcase
    end
  end

  // mode decode
  assign window_mode = (relay_mode == MODE_ALARM);
  assign invert      = !window_mode && (relay_mode != MODE_NORMAL);

  // sign-extended operands, window bounds scaled by ten as 8x + 2x
  assign temp_w = {temperature[TempW-1], temperature};
  assign thr_w  = {threshold[TempW-1], threshold};
  assign band   = WideW'(hysteresis >> HystShift);
  assign upper  = thr_w + band;
  assign lower  = thr_w - band;
  assign win_lo = {{(WideW-AlarmW-3){alarm_low[AlarmW-1]}}, alarm_low, 3'b000}
                + {{(WideW-AlarmW-1){alarm_low[AlarmW-1]}}, alarm_low, 1'b0};
  assign win_hi = {{(WideW-AlarmW-3){alarm_high[AlarmW-1]}}, alarm_high, 3'b000}
                + {{(WideW-AlarmW-1){alarm_high[AlarmW-1]}}, alarm_high, 1'b0};

  // delay limit and counter step
  assign limit     = CountW'(switch_delay) << DelayShift;
  assign count_inc = delay_count + CountW'(1);
  assign cond      = active_flag ? (temp_w < lower) : (temp_w > upper);

  // next flag and counter for the sample on the input port
  always_comb begin
    active_flag_next = active_flag;
    delay_count_next = delay_count;
    if (window_mode) begin
      if (active_flag) begin
        if (temp_w > win_lo && temp_w < win_hi) active_flag_next = 1'b0;
      end else begin
        if (temp_w <= win_lo || temp_w >= win_hi) active_flag_next = 1'b1;
      end
    end else if (cond) begin
      delay_count_next = count_inc;
      if (limit < count_inc) active_flag_next = !active_flag;
    end else begin
      delay_count_next = '0;
    end
  end

  // state update on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      active_flag <= 1'b0;
      delay_count <= '0;
    end else if (in_xfer) begin
      active_flag <= active_flag_next;
      delay_count <= delay_count_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      active   <= active_flag_next;
      relay_on <= active_flag_next ^ invert;
    end
  end

endmodule

@@ rtl/trc_checker.sv @@
// trc_checker: port-level assertions for thermostat_relay_controller
// bound to the top level at the end of this file
// needs only the handshake and result ports
module trc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic relay_on,
  input logic active,
  input logic cfg_valid,
  input logic cfg_ready
);

  // an empty result register never blocks input
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // every accepted sample produces a result in the next cycle
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> out_valid)
    else $error("accepted sample produced no result");

  // a stalled result blocks further input so nothing is overwritten
  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(relay_on) && $stable(active)))
    else $error("stalled result changed");

  // config writes never wait
  assert property (@(posedge clk) disable iff (rst) cfg_valid |-> cfg_ready)
    else $error("config transaction stalled");

endmodule

bind thermostat_relay_controller trc_checker u_trc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .relay_on    (relay_on),
  .active      (active),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);
